@@ hw/rtl/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// Types, codes and constants shared by the landing / tracking PID controller.
// ----------------------------------------------------------------------------
package lpm_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_TAKEOFF   = 3'd1,
    MODE_TRACKING  = 3'd2,
    MODE_SEARCHING = 3'd3,
    MODE_LANDING   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_TARGET  = 3'd1,
    REQ_ALT     = 3'd2,
    REQ_TAKEOFF = 3'd3,
    REQ_LAND    = 3'd4
  } req_t;

  // what the output stage does with the horizontal command
  typedef enum logic [1:0] {
    VOP_KEEP,
    VOP_ZERO,
    VOP_PID
  } vop_t;

  localparam logic [2:0] CFG_GAIN_P       = 3'd0;
  localparam logic [2:0] CFG_GAIN_I       = 3'd1;
  localparam logic [2:0] CFG_GAIN_D       = 3'd2;
  localparam logic [2:0] CFG_CLIMB_DONE   = 3'd3;
  localparam logic [2:0] CFG_TOUCHDOWN    = 3'd4;
  localparam logic [2:0] CFG_SLOW_DESCENT = 3'd5;
  localparam logic [2:0] CFG_CEILING      = 3'd6;
  localparam logic [2:0] CFG_LOST_LIMIT   = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] VZ_CLIMB = 16'sd256;
  localparam logic signed [15:0] VZ_FAST  = -16'sd102;
  localparam logic signed [15:0] VZ_SLOW  = -16'sd77;
  localparam logic [7:0]         TICK_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] err_x;
    logic signed [15:0] err_y;
    logic [15:0]        altitude_mm;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [2:0]         mode;
    logic               send;
  } out_item_t;

  typedef struct packed {
    logic [15:0] p;
    logic [15:0] i;
    logic [15:0] d;
  } gains_t;

  typedef struct packed {
    logic signed [15:0] e;
    logic signed [31:0] integ;
    logic signed [15:0] prev;
  } lane_in_t;

  typedef struct packed {
    vop_t               op;
    logic signed [15:0] vel_z;
    mode_t              mode;
    logic               send;
  } meta_t;

  typedef struct packed {
    meta_t    meta;
    lane_in_t lx;
    lane_in_t ly;
  } stage1_t;

endpackage

@@ hw/rtl/lpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpm_ctrl
// Configuration registers, flight-mode state machine and integrators.
// Updates all control state on each accepted beat and issues one PID job.
// ----------------------------------------------------------------------------
module lpm_ctrl import lpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  in_item_t              in_data,
  output stage1_t               s1_r,
  output gains_t                gains
);

  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [15:0] climb_r, touch_r, slow_r, ceil_r;
  logic [7:0]  lost_r;

  mode_t              mode_r, mode_nxt;
  logic signed [31:0] integ_x_r, integ_x_nxt, integ_y_r, integ_y_nxt;
  logic signed [15:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [15:0] vz_r, vz_nxt;
  logic [15:0]        alt_r, alt_nxt;
  logic [7:0]         ticks_r, ticks_nxt;
  logic signed [31:0] add_x, add_y;
  vop_t               op;
  logic               send;
  logic               clr;
  stage1_t            s1_nxt;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  assign add_x = sat_add(integ_x_r, in_data.err_x);
  assign add_y = sat_add(integ_y_r, in_data.err_y);

  always_comb begin
    mode_nxt    = mode_r;
    integ_x_nxt = integ_x_r;
    integ_y_nxt = integ_y_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    vz_nxt      = vz_r;
    alt_nxt     = alt_r;
    ticks_nxt   = ticks_r;
    op          = VOP_KEEP;
    send        = 1'b0;
    clr         = 1'b0;
    unique case (in_data.req_type)
      REQ_TICK: begin
        if (ticks_r < TICK_MAX) begin
          ticks_nxt = ticks_r + 8'd1;
        end
        send = (mode_r != MODE_IDLE);
        if (mode_nxt == MODE_TAKEOFF) begin
          clr    = 1'b1;
          op     = VOP_ZERO;
          vz_nxt = VZ_CLIMB;
          if (alt_r > climb_r) begin
            vz_nxt   = '0;
            mode_nxt = MODE_TRACKING;
          end
        end
        if (mode_nxt == MODE_LANDING && ticks_nxt > lost_r) begin
          mode_nxt = MODE_TAKEOFF;
          clr      = 1'b1;
        end
        if (mode_nxt == MODE_LANDING && alt_r < touch_r) begin
          mode_nxt = MODE_IDLE;
          op       = VOP_ZERO;
          clr      = 1'b1;
          send     = 1'b1;
        end
        if (mode_nxt == MODE_TRACKING && ticks_nxt > lost_r) begin
          mode_nxt = MODE_SEARCHING;
          clr      = 1'b1;
        end
      end
      REQ_TARGET: begin
        if (mode_r == MODE_SEARCHING) begin
          mode_nxt = MODE_TRACKING;
        end
        ticks_nxt = '0;
        if (mode_nxt == MODE_TRACKING || mode_nxt == MODE_LANDING) begin
          integ_x_nxt = add_x;
          integ_y_nxt = add_y;
          prev_x_nxt  = in_data.err_x;
          prev_y_nxt  = in_data.err_y;
          op          = VOP_PID;
          if (mode_nxt == MODE_LANDING) begin
            if (alt_r <= ceil_r && alt_r > slow_r) begin
              vz_nxt = VZ_FAST;
            end else if (alt_r <= slow_r) begin
              vz_nxt = VZ_SLOW;
            end
          end
        end
      end
      REQ_ALT:     alt_nxt  = in_data.altitude_mm;
      REQ_TAKEOFF: mode_nxt = MODE_TAKEOFF;
      REQ_LAND:    mode_nxt = MODE_LANDING;
      default: ;
    endcase
    if (clr) begin
      integ_x_nxt = '0;
      integ_y_nxt = '0;
      prev_x_nxt  = '0;
      prev_y_nxt  = '0;
    end
  end

  always_comb begin
    s1_nxt.meta.op    = op;
    s1_nxt.meta.vel_z = vz_nxt;
    s1_nxt.meta.mode  = mode_nxt;
    s1_nxt.meta.send  = send;
    s1_nxt.lx.e       = in_data.err_x;
    s1_nxt.lx.integ   = integ_x_nxt;
    s1_nxt.lx.prev    = prev_x_r;
    s1_nxt.ly.e       = in_data.err_y;
    s1_nxt.ly.integ   = integ_y_nxt;
    s1_nxt.ly.prev    = prev_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'd6849;
      gain_i_r <= 16'd98;
      gain_d_r <= 16'd524;
      climb_r  <= 16'd5000;
      touch_r  <= 16'd180;
      slow_r   <= 16'd2000;
      ceil_r   <= 16'd10000;
      lost_r   <= 8'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GAIN_P:       gain_p_r <= cfg_data;
        CFG_GAIN_I:       gain_i_r <= cfg_data;
        CFG_GAIN_D:       gain_d_r <= cfg_data;
        CFG_CLIMB_DONE:   climb_r  <= cfg_data;
        CFG_TOUCHDOWN:    touch_r  <= cfg_data;
        CFG_SLOW_DESCENT: slow_r   <= cfg_data;
        CFG_CEILING:      ceil_r   <= cfg_data;
        CFG_LOST_LIMIT:   lost_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      integ_x_r <= '0;
      integ_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      vz_r      <= '0;
      alt_r     <= '0;
      ticks_r   <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      integ_x_r <= integ_x_nxt;
      integ_y_r <= integ_y_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
      vz_r      <= vz_nxt;
      alt_r     <= alt_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign gains.p = gain_p_r;
  assign gains.i = gain_i_r;
  assign gains.d = gain_d_r;

endmodule

@@ hw/rtl/lpm_pid_lane.sv @@
// ----------------------------------------------------------------------------
// lpm_pid_lane
// One axis of the PID: registered products, registered sum, then rounding
// to nearest (halves up) and saturation to 16 bits.
// ----------------------------------------------------------------------------
module lpm_pid_lane import lpm_pkg::*; (
  input  logic               clk,
  input  logic               en2,
  input  logic               en3,
  input  lane_in_t           din,
  input  gains_t             gains,
  output logic signed [15:0] vel
);

  logic signed [16:0] diff;
  logic signed [32:0] prod_p_r, prod_p_nxt;
  logic signed [48:0] prod_i_r, prod_i_nxt;
  logic signed [33:0] prod_d_r, prod_d_nxt;
  logic signed [49:0] sum_r, sum_nxt;
  logic signed [49:0] rnd;
  logic signed [33:0] quo;

  assign diff       = {din.e[15], din.e} - {din.prev[15], din.prev};
  assign prod_p_nxt = $signed({1'b0, gains.p}) * din.e;
  assign prod_i_nxt = $signed({1'b0, gains.i}) * din.integ;
  assign prod_d_nxt = $signed({1'b0, gains.d}) * diff;

  assign sum_nxt = 50'(prod_p_r) + 50'(prod_i_r) + 50'(prod_d_r);

  assign rnd = sum_r + 50'sd32768;
  assign quo = rnd[49:16];

  always_comb begin
    if (quo > 34'sd32767) begin
      vel = 16'sh7fff;
    end else if (quo < -34'sd32768) begin
      vel = 16'sh8000;
    end else begin
      vel = quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (en3) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

@@ hw/rtl/lpm_merge.sv @@
// ----------------------------------------------------------------------------
// lpm_merge
// Output register: joins both lane results with the mode, vertical rate and
// send flag. Its vel_x/vel_y fields double as the commanded-velocity state.
// ----------------------------------------------------------------------------
module lpm_merge import lpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  meta_t              meta,
  input  logic signed [15:0] lane_x,
  input  logic signed [15:0] lane_y,
  output out_item_t          out_r
);

  out_item_t out_nxt;

  always_comb begin
    out_nxt       = out_r;
    out_nxt.vel_z = meta.vel_z;
    out_nxt.mode  = meta.mode;
    out_nxt.send  = meta.send;
    unique case (meta.op)
      VOP_ZERO: begin
        out_nxt.vel_x = '0;
        out_nxt.vel_y = '0;
      end
      VOP_PID: begin
        out_nxt.vel_x = lane_x;
        out_nxt.vel_y = lane_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '{vel_x: '0, vel_y: '0, vel_z: '0, mode: MODE_IDLE, send: 1'b0};
    end else if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ hw/rtl/landing_tracking_pid_mode_control_top.sv @@
// ----------------------------------------------------------------------------
// landing_tracking_pid_mode_control_top
// Two-axis PID tracking controller with a take-off / track / search / land
// flight-mode state machine, Q8.8 fixed point.
//
// Input beats (in_valid / in_stall) carry one event: tick, target error,
// altitude, take-off or land. Every event yields exactly one output beat
// (out_valid / out_stall) with the commanded velocity, mode and send flag.
// Mode and integrator state update in the accept cycle; the x and y PID
// lanes then register products and sum, and round/saturate into the
// output register. One beat is accepted per cycle while the pipeline is
// not full; the four-stage pipeline has no feedback from the PID result
// back to the state machine. A stalled output holds its beat; the pipeline
// stages behind it keep filling and in_stall rises only when all four
// stages are full. cfg_we / cfg_idx / cfg_data write one register per
// cycle; the user must write only while the block is idle, which the block
// does not enforce. Reset (rst_n low, synchronous) restores register
// defaults, sets mode idle, clears velocities and empties the pipeline.
// ----------------------------------------------------------------------------
module landing_tracking_pid_mode_control_top import lpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic               v1_r, v2_r, v3_r, out_valid_r;
  logic               adv_o, en1, en2, en3, accept;
  stage1_t            s1;
  gains_t             gains;
  meta_t              meta2_r, meta3_r;
  logic signed [15:0] lane_x, lane_y;

  assign adv_o  = !out_valid_r || !out_stall;
  assign en3    = !v3_r || adv_o;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign accept = in_valid && en1;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_data  (in_data),
    .s1_r     (s1),
    .gains    (gains)
  );

  lpm_pid_lane u_lane_x (
    .clk   (clk),
    .en2   (en2),
    .en3   (en3),
    .din   (s1.lx),
    .gains (gains),
    .vel   (lane_x)
  );

  lpm_pid_lane u_lane_y (
    .clk   (clk),
    .en2   (en2),
    .en3   (en3),
    .din   (s1.ly),
    .gains (gains),
    .vel   (lane_y)
  );

  lpm_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (v3_r && adv_o),
    .meta   (meta3_r),
    .lane_x (lane_x),
    .lane_y (lane_y),
    .out_r  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= accept;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (adv_o) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      meta2_r <= s1.meta;
    end
    if (en3) begin
      meta3_r <= meta2_r;
    end
  end

endmodule

@@ hw/rtl/lpm_checker.sv @@
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks for the landing / tracking PID controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module lpm_checker import lpm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // held output beat does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // idle is only entered by reset or touchdown, which both zero the horizontal command
  a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mode == MODE_IDLE |-> out_data.vel_x == 16'sd0
      && out_data.vel_y == 16'sd0)
    else $error("horizontal velocity nonzero in idle");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // an empty output stage must never block the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_stall |=> out_valid)
    else $error("input stalled with output stage empty");

endmodule

bind landing_tracking_pid_mode_control_top lpm_checker u_lpm_checker (.*);

@@ tb/sv/landing_tracking_pid_mode_control_top_tb.sv @@
// ----------------------------------------------------------------------------
// landing_tracking_pid_mode_control_top_tb
// Self-checking bench for the two-axis PID / flight-mode controller. A short
// table of directed events (reset state, field extremes, every event type,
// climb, track, descent rates, touchdown) runs first. Random phases under
// several register settings follow, with zeros and all-ones among them. Each
// output beat is compared field by field with a table entry or an in-bench flight model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module landing_tracking_pid_mode_control_top_tb;
  import lpm_pkg::*;

  localparam logic [2:0]         REQ_RSVD_LO = 3'd5;
  localparam logic [2:0]         REQ_RSVD_HI = 3'd7;
  localparam logic signed [15:0] E_MAX       = 16'sh7fff;
  localparam logic signed [15:0] E_MIN       = 16'sh8000;
  localparam logic [15:0]        ALT_TOP     = 16'hffff;
  localparam out_item_t          HOLD_IDLE   = '{16'sd0, 16'sd0, 16'sd0, MODE_IDLE, 1'b0};

  typedef struct packed {
    in_item_t  it;
    logic      chk;
    out_item_t want;
  } stim_row_t;

  localparam int N_STIM = 24;
  localparam stim_row_t STIM [N_STIM] = '{
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b1, HOLD_IDLE},
    '{'{REQ_TARGET, E_MAX, E_MIN, 16'd0}, 1'b1, HOLD_IDLE},
    '{'{REQ_RSVD_LO, E_MIN, E_MAX, ALT_TOP}, 1'b1, HOLD_IDLE},
    '{'{REQ_RSVD_HI, 16'sh5555, 16'shaaaa, 16'h5555}, 1'b1, HOLD_IDLE},
    '{'{REQ_ALT, E_MAX, E_MAX, 16'd0}, 1'b1, HOLD_IDLE},
    '{'{REQ_TAKEOFF, E_MIN, E_MIN, ALT_TOP}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, MODE_TAKEOFF, 1'b0}},
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b1,
      '{16'sd0, 16'sd0, VZ_CLIMB, MODE_TAKEOFF, 1'b1}},
    '{'{REQ_ALT, 16'sd0, 16'sd0, ALT_TOP}, 1'b1,
      '{16'sd0, 16'sd0, VZ_CLIMB, MODE_TAKEOFF, 1'b0}},
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b1,
      '{16'sd0, 16'sd0, 16'sd0, MODE_TRACKING, 1'b1}},
    '{'{REQ_TARGET, E_MAX, E_MIN, 16'd0}, 1'b0, '0},
    '{'{REQ_TARGET, E_MIN, E_MAX, 16'd0}, 1'b0, '0},
    '{'{REQ_TARGET, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0},
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0},
    '{'{REQ_LAND, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0},
    '{'{REQ_ALT, 16'sd0, 16'sd0, 16'd10000}, 1'b0, '0},
    '{'{REQ_TARGET, 16'sd256, -16'sd256, 16'd0}, 1'b0, '0},
    '{'{REQ_ALT, 16'sd0, 16'sd0, 16'd2000}, 1'b0, '0},
    '{'{REQ_TARGET, -16'sd256, 16'sd256, 16'd0}, 1'b0, '0},
    '{'{REQ_ALT, 16'sd0, 16'sd0, 16'd10001}, 1'b0, '0},
    '{'{REQ_TARGET, 16'sd1, -16'sd1, 16'd0}, 1'b0, '0},
    '{'{REQ_ALT, 16'sd0, 16'sd0, 16'd179}, 1'b0, '0},
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0},
    '{'{REQ_TICK, 16'sd0, 16'sd0, 16'd0}, 1'b1,
      '{16'sd0, 16'sd0, VZ_SLOW, MODE_IDLE, 1'b0}},
    '{'{REQ_LAND, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  // flight model state and register copy
  mode_t              fm;
  logic signed [31:0] integ_x_m, integ_y_m;
  logic signed [15:0] prev_x_m, prev_y_m;
  logic signed [15:0] vx_m, vy_m, vz_m;
  logic [15:0]        alt_m;
  logic [7:0]         unseen_m;
  logic [15:0]        kp, ki, kd, climb_mm, touch_mm, slow_mm, ceil_mm;
  logic [7:0]         lost_lim;

  out_item_t pending_cmds [$];
  int        mismatches = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;
  int        hold_cycles = 0;

  landing_tracking_pid_mode_control_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_pid();
    integ_x_m = '0;
    integ_y_m = '0;
    prev_x_m  = '0;
    prev_y_m  = '0;
  endfunction

  function automatic logic signed [31:0] sat_acc(logic signed [31:0] a, logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [15:0] pid_out(logic signed [15:0] e,
                                                 logic signed [31:0] acc,
                                                 logic signed [15:0] prev);
    longint s;
    s = longint'(kp) * longint'(e) + longint'(ki) * longint'(acc)
      + longint'(kd) * (longint'(e) - longint'(prev));
    s = (s + 64'sd32768) >>> 16;
    if (s > 64'sd32767) return 16'sh7fff;
    if (s < -64'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

  function automatic out_item_t fly_step(in_item_t it);
    out_item_t r;
    logic      snd;
    snd = 1'b0;
    case (it.req_type)
      REQ_TICK: begin
        if (unseen_m != TICK_MAX) unseen_m = unseen_m + 8'd1;
        snd = (fm != MODE_IDLE);
        if (fm == MODE_TAKEOFF) begin
          clear_pid();
          vx_m = '0;
          vy_m = '0;
          vz_m = VZ_CLIMB;
          if (alt_m > climb_mm) begin
            vz_m = '0;
            fm   = MODE_TRACKING;
          end
        end
        if (fm == MODE_LANDING && unseen_m > lost_lim) begin
          fm = MODE_TAKEOFF;
          clear_pid();
        end
        if (fm == MODE_LANDING && alt_m < touch_mm) begin
          fm   = MODE_IDLE;
          vx_m = '0;
          vy_m = '0;
          clear_pid();
          snd  = 1'b1;
        end
        if (fm == MODE_TRACKING && unseen_m > lost_lim) begin
          fm = MODE_SEARCHING;
          clear_pid();
        end
      end
      REQ_TARGET: begin
        if (fm == MODE_SEARCHING) fm = MODE_TRACKING;
        unseen_m = '0;
        if (fm == MODE_TRACKING || fm == MODE_LANDING) begin
          integ_x_m = sat_acc(integ_x_m, it.err_x);
          integ_y_m = sat_acc(integ_y_m, it.err_y);
          vx_m      = pid_out(it.err_x, integ_x_m, prev_x_m);
          vy_m      = pid_out(it.err_y, integ_y_m, prev_y_m);
          prev_x_m  = it.err_x;
          prev_y_m  = it.err_y;
          if (fm == MODE_LANDING) begin
            if (alt_m <= ceil_mm && alt_m > slow_mm) vz_m = VZ_FAST;
            else if (alt_m <= slow_mm) vz_m = VZ_SLOW;
          end
        end
      end
      REQ_ALT:     alt_m = it.altitude_mm;
      REQ_TAKEOFF: fm = MODE_TAKEOFF;
      REQ_LAND:    fm = MODE_LANDING;
      default: ;
    endcase
    r.vel_x = vx_m;
    r.vel_y = vy_m;
    r.vel_z = vz_m;
    r.mode  = fm;
    r.send  = snd;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic apply_cfg(input logic [15:0] p, i, d, cl, td, sd, ce, input logic [7:0] ll);
    logic [15:0] vals [8];
    vals[CFG_GAIN_P]       = p;
    vals[CFG_GAIN_I]       = i;
    vals[CFG_GAIN_D]       = d;
    vals[CFG_CLIMB_DONE]   = cl;
    vals[CFG_TOUCHDOWN]    = td;
    vals[CFG_SLOW_DESCENT] = sd;
    vals[CFG_CEILING]      = ce;
    vals[CFG_LOST_LIMIT]   = {8'd0, ll};
    for (int n = 0; n < 8; n++) begin
      @(negedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(n);
      cfg_data <= vals[n];
    end
    @(negedge clk);
    cfg_we   <= 1'b0;
    kp       = p;
    ki       = i;
    kd       = d;
    climb_mm = cl;
    touch_mm = td;
    slow_mm  = sd;
    ceil_mm  = ce;
    lost_lim = ll;
  endtask

  task automatic offer(in_item_t it, logic chk, out_item_t typed);
    int        gap;
    out_item_t pred;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = fly_step(it);
    pending_cmds.push_back(chk ? typed : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n_items, bit pause_mid);
    in_item_t it;
    int       r;
    for (int k = 0; k < n_items; k++) begin
      if (pause_mid && k == n_items / 2) drain();
      it.err_x = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
      it.err_y = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
      case ($urandom_range(0, 9))
        0:       it.altitude_mm = 16'd0;
        1:       it.altitude_mm = ALT_TOP;
        2:       it.altitude_mm = climb_mm;
        3:       it.altitude_mm = climb_mm + 16'd1;
        4:       it.altitude_mm = touch_mm - 16'd1;
        5:       it.altitude_mm = touch_mm;
        6:       it.altitude_mm = slow_mm + 16'($urandom_range(0, 1));
        7:       it.altitude_mm = ceil_mm + 16'($urandom_range(0, 1));
        default: it.altitude_mm = 16'($urandom);
      endcase
      r = $urandom_range(0, 99);
      if (r < 38)      it.req_type = REQ_TICK;
      else if (r < 64) it.req_type = REQ_TARGET;
      else if (r < 82) it.req_type = REQ_ALT;
      else if (r < 88) it.req_type = REQ_TAKEOFF;
      else if (r < 96) it.req_type = REQ_LAND;
      else             it.req_type = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
      // idle goes nowhere without a take-off, so nudge it along
      if (fm == MODE_IDLE && $urandom_range(0, 3) == 0) it.req_type = REQ_TAKEOFF;
      offer(it, 1'b0, '0);
    end
  endtask

  // result receiver: random stall per beat, plus one long hold-off on request
  initial begin : result_sink
    int k;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        k = hold_cycles;
        hold_cycles = 0;
      end else begin
        k = rx_idle ? $urandom_range(0, 13) : 0;
      end
      repeat (k) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch("beat with nothing pending, mode", out_data.mode, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_data.vel_x !== want.vel_x) flag_mismatch("vel_x", out_data.vel_x, want.vel_x);
        if (out_data.vel_y !== want.vel_y) flag_mismatch("vel_y", out_data.vel_y, want.vel_y);
        if (out_data.vel_z !== want.vel_z) flag_mismatch("vel_z", out_data.vel_z, want.vel_z);
        if (out_data.mode !== want.mode) flag_mismatch("mode", out_data.mode, want.mode);
        if (out_data.send !== want.send) flag_mismatch("send", out_data.send, want.send);
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : main_seq
    logic [15:0] sd;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;
    kp       = 16'd6849;
    ki       = 16'd98;
    kd       = 16'd524;
    climb_mm = 16'd5000;
    touch_mm = 16'd180;
    slow_mm  = 16'd2000;
    ceil_mm  = 16'd10000;
    lost_lim = 8'd100;
    fm       = MODE_IDLE;
    clear_pid();
    vx_m     = '0;
    vy_m     = '0;
    vz_m     = '0;
    alt_m    = '0;
    unseen_m = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_STIM; k++) offer(STIM[k].it, STIM[k].chk, STIM[k].want);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: apply_cfg('0, '0, '0, '0, '0, '0, '0, 8'd0);
        1: apply_cfg('1, '1, '1, '1, '1, '1, '1, 8'hff);
        2: apply_cfg(16'd6849, 16'd98, 16'd524, 16'd5000, 16'd180, 16'd2000, 16'd10000, 8'd3);
        default: begin
          sd = 16'($urandom_range(0, 6000));
          apply_cfg(16'($urandom), 16'($urandom_range(0, 4000)), 16'($urandom),
                    16'($urandom_range(0, 12000)), 16'($urandom_range(0, 1500)), sd,
                    sd + 16'($urandom_range(0, 15000)), 8'($urandom_range(0, 10)));
        end
      endcase
      tx_idle = (ph % 4 < 2);
      rx_idle = (ph % 4 == 0 || ph % 4 == 2);
      // back-to-back beats against a receiver that holds off long enough to fill the pipe
      if (ph == 3) hold_cycles = 80;
      run_phase(200, ph == 5);
    end

    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
